>>> rtl/core/k_permutation_enumerator_assert.svh
// assertion macros used by the enumerator datapath (kpe_dp)
// each macro expects clk and rst_n in scope
`ifndef K_PERMUTATION_ENUMERATOR_ASSERT_SVH
`define K_PERMUTATION_ENUMERATOR_ASSERT_SVH
`ifndef SYNTH
`define KPE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kpe assertion failed");
`define KPE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kpe assertion failed");
`else
`define KPE_ASSERT_NOW(lbl, ante, cons)
`define KPE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> rtl/core/kpe_pkg.sv
package kpe_pkg;

  localparam int KPE_MAX_SET_DEF   = 16;
  localparam int KPE_MAX_TUPLE_DEF = 16;

  localparam int ELEM_W    = 5;
  localparam int SCAN_W    = ELEM_W + 1;
  localparam int POS_W     = 4;
  localparam int ORD_W     = 32;
  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SET_SIZE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TUPLE_LEN = 1'd1;

  localparam logic [CFG_W-1:0] SET_SIZE_RST  = 5'd4;
  localparam logic [CFG_W-1:0] TUPLE_LEN_RST = 5'd2;

  typedef struct packed {
    logic start;
    logic set_done;
    logic init_step;
    logic count_one;
    logic adv_begin;
    logic rd_pos;
    logic release_val;
    logic scan_inc;
    logic pos_dec;
    logic take_pos;
    logic fill_take;
    logic count_inc;
    logic emit_elem;
    logic emit_exh;
  } cmd_t;

  typedef struct packed {
    logic started;
    logic done;
    logic sizes_ok;
    logic idx_at_k;
    logic idx_last;
    logic pos_zero;
    logic scan_over;
    logic scan_free;
    logic out_free;
  } sts_t;

endpackage

>>> rtl/core/kpe_ram.sv
module kpe_ram
  #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
  )
  (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
  );

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/kpe_ctrl.sv
module kpe_ctrl
  import kpe_pkg::*;
  (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  logic in_restart,
    input  sts_t sts,
    output cmd_t cmd
  );

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_INIT     = 4'd1;
  localparam logic [3:0] ST_ADV_RD   = 4'd2;
  localparam logic [3:0] ST_ADV_REL  = 4'd3;
  localparam logic [3:0] ST_ADV_SCAN = 4'd4;
  localparam logic [3:0] ST_FILL     = 4'd5;
  localparam logic [3:0] ST_EMIT_RD  = 4'd6;
  localparam logic [3:0] ST_EMIT_OUT = 4'd7;
  localparam logic [3:0] ST_EXH      = 4'd8;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_restart || !sts.started) begin
            cmd.start = 1'b1;
            if (sts.sizes_ok) begin
              state_nxt = ST_INIT;
            end else begin
              cmd.set_done = 1'b1;
              state_nxt    = ST_EXH;
            end
          end else if (sts.done) begin
            state_nxt = ST_EXH;
          end else begin
            cmd.adv_begin = 1'b1;
            state_nxt     = ST_ADV_RD;
          end
        end
      end
      ST_INIT: begin
        if (sts.idx_at_k) begin
          cmd.count_one = 1'b1;
          state_nxt     = ST_EMIT_RD;
        end else begin
          cmd.init_step = 1'b1;
        end
      end
      ST_ADV_RD: begin
        cmd.rd_pos = 1'b1;
        state_nxt  = ST_ADV_REL;
      end
      ST_ADV_REL: begin
        cmd.rd_pos      = 1'b1;
        cmd.release_val = 1'b1;
        state_nxt       = ST_ADV_SCAN;
      end
      ST_ADV_SCAN: begin
        if (sts.scan_over) begin
          // this position cannot be raised: back off one place, or finish at position zero
          if (sts.pos_zero) begin
            cmd.set_done = 1'b1;
            state_nxt    = ST_EXH;
          end else begin
            cmd.pos_dec = 1'b1;
            state_nxt   = ST_ADV_RD;
          end
        end else if (sts.scan_free) begin
          cmd.take_pos = 1'b1;
          state_nxt    = ST_FILL;
        end else begin
          cmd.scan_inc = 1'b1;
        end
      end
      ST_FILL: begin
        if (sts.idx_at_k) begin
          cmd.count_inc = 1'b1;
          state_nxt     = ST_EMIT_RD;
        end else if (sts.scan_free) begin
          cmd.fill_take = 1'b1;
        end else begin
          cmd.scan_inc = 1'b1;
        end
      end
      ST_EMIT_RD: begin
        state_nxt = ST_EMIT_OUT;
      end
      ST_EMIT_OUT: begin
        if (sts.out_free) begin
          cmd.emit_elem = 1'b1;
          state_nxt     = sts.idx_last ? ST_IDLE : ST_EMIT_RD;
        end
      end
      ST_EXH: begin
        if (sts.out_free) begin
          cmd.emit_exh = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/core/kpe_dp.sv
`include "k_permutation_enumerator_assert.svh"

module kpe_dp
  import kpe_pkg::*;
  #(
    parameter int MAX_SET   = KPE_MAX_SET_DEF,
    parameter int MAX_TUPLE = KPE_MAX_TUPLE_DEF
  )
  (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  cmd_t                 cmd,
    output sts_t                 sts,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [ELEM_W-1:0]    out_element,
    output logic [POS_W-1:0]     out_position,
    output logic [ORD_W-1:0]     out_ordinal,
    output logic                 out_last,
    output logic                 out_exhausted
  );

  localparam int ADDR_W = (MAX_TUPLE > 1) ? $clog2(MAX_TUPLE) : 1;
  localparam int CNT_W  = $clog2(MAX_TUPLE + 1);
  localparam int IDX_W  = $clog2(MAX_SET);

  logic [CFG_W-1:0]   set_size_r;
  logic [CFG_W-1:0]   tuple_len_r;
  logic               started_r;
  logic               done_r;
  logic [MAX_SET-1:0] used_r;
  logic [MAX_SET-1:0] used_nxt;
  logic [ORD_W-1:0]   count_r;
  logic [SCAN_W-1:0]  scan_r;
  logic [ADDR_W-1:0]  pos_r;
  logic [CNT_W-1:0]   idx_r;

  logic               out_valid_r;
  logic [ELEM_W-1:0]  out_element_r;
  logic [POS_W-1:0]   out_position_r;
  logic [ORD_W-1:0]   out_ordinal_r;
  logic               out_last_r;
  logic               out_exhausted_r;

  logic [CNT_W-1:0]   k_cnt;
  logic [IDX_W-1:0]   scan_bit;
  logic [IDX_W-1:0]   rd_bit;
  logic [IDX_W-1:0]   init_bit;
  logic [ELEM_W-1:0]  init_val;
  logic [ELEM_W-1:0]  rdata;
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [ELEM_W-1:0]  ram_wdata;
  logic [ADDR_W-1:0]  ram_raddr;
  logic               out_free;

  assign k_cnt    = CNT_W'(tuple_len_r);
  assign scan_bit = IDX_W'(scan_r - 1'b1);
  assign rd_bit   = IDX_W'(rdata - 1'b1);
  assign init_bit = IDX_W'(idx_r);
  assign init_val = ELEM_W'(idx_r) + 1'b1;
  assign out_free = !out_valid_r || out_ready;

  assign sts.started   = started_r;
  assign sts.done      = done_r;
  assign sts.sizes_ok  = (set_size_r != '0) && (tuple_len_r != '0) &&
                         (tuple_len_r <= set_size_r) &&
                         (32'(set_size_r) <= 32'(MAX_SET)) &&
                         (32'(tuple_len_r) <= 32'(MAX_TUPLE));
  assign sts.idx_at_k  = (idx_r == k_cnt);
  assign sts.idx_last  = (idx_r == k_cnt - 1'b1);
  assign sts.pos_zero  = (pos_r == '0);
  assign sts.scan_over = (scan_r > SCAN_W'(set_size_r));
  assign sts.scan_free = !used_r[scan_bit];
  assign sts.out_free  = out_free;

  // tuple storage write port: init, raised position or refill
  always_comb begin
    ram_we    = cmd.init_step || cmd.take_pos || cmd.fill_take;
    ram_waddr = ADDR_W'(idx_r);
    ram_wdata = ELEM_W'(scan_r);
    if (cmd.init_step) begin
      ram_wdata = init_val;
    end else if (cmd.take_pos) begin
      ram_waddr = pos_r;
    end
    ram_raddr = cmd.rd_pos ? pos_r : ADDR_W'(idx_r);
  end

  kpe_ram #(
    .WIDTH (ELEM_W),
    .DEPTH (MAX_TUPLE)
  ) u_tuple_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  always_comb begin
    used_nxt = used_r;
    if (cmd.start) begin
      used_nxt = '0;
    end else if (cmd.init_step) begin
      used_nxt[init_bit] = 1'b1;
    end else if (cmd.release_val) begin
      used_nxt[rd_bit] = 1'b0;
    end else if (cmd.take_pos || cmd.fill_take) begin
      used_nxt[scan_bit] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_size_r  <= SET_SIZE_RST;
      tuple_len_r <= TUPLE_LEN_RST;
      started_r   <= 1'b0;
      done_r      <= 1'b0;
      used_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SET_SIZE:  set_size_r  <= cfg_wdata;
          REG_TUPLE_LEN: tuple_len_r <= cfg_wdata;
          default: begin
          end
        endcase
        started_r <= 1'b0;
      end else if (cmd.start) begin
        started_r <= 1'b1;
      end
      if (cmd.set_done) begin
        done_r <= 1'b1;
      end else if (cmd.start) begin
        done_r <= 1'b0;
      end
      used_r <= used_nxt;
      if (cmd.start) begin
        count_r <= '0;
      end else if (cmd.count_one) begin
        count_r <= ORD_W'(1);
      end else if (cmd.count_inc && (count_r != '1)) begin
        count_r <= count_r + 1'b1;
      end
      if (cmd.emit_elem || cmd.emit_exh) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // working counters and result payload
  always_ff @(posedge clk) begin
    if (cmd.start || cmd.count_one || cmd.count_inc) begin
      idx_r <= '0;
    end else if (cmd.init_step || cmd.fill_take || cmd.emit_elem) begin
      idx_r <= idx_r + 1'b1;
    end else if (cmd.take_pos) begin
      idx_r <= CNT_W'(pos_r) + 1'b1;
    end
    if (cmd.adv_begin) begin
      pos_r <= ADDR_W'(k_cnt - 1'b1);
    end else if (cmd.pos_dec) begin
      pos_r <= pos_r - 1'b1;
    end
    if (cmd.release_val) begin
      scan_r <= SCAN_W'(rdata) + 1'b1;
    end else if (cmd.take_pos) begin
      scan_r <= SCAN_W'(1);
    end else if (cmd.scan_inc || cmd.fill_take) begin
      scan_r <= scan_r + 1'b1;
    end
    if (cmd.emit_elem) begin
      out_element_r   <= rdata;
      out_position_r  <= POS_W'(idx_r);
      out_ordinal_r   <= count_r;
      out_last_r      <= sts.idx_last;
      out_exhausted_r <= 1'b0;
    end else if (cmd.emit_exh) begin
      out_element_r   <= '0;
      out_position_r  <= '0;
      out_ordinal_r   <= count_r;
      out_last_r      <= 1'b1;
      out_exhausted_r <= 1'b1;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_element   = out_element_r;
  assign out_position  = out_position_r;
  assign out_ordinal   = out_ordinal_r;
  assign out_last      = out_last_r;
  assign out_exhausted = out_exhausted_r;

  `KPE_ASSERT_NOW(a_exh_shape, out_valid_r && out_exhausted_r, (out_element_r == '0) && out_last_r)
  `KPE_ASSERT_NOW(a_elem_nonzero, out_valid_r && !out_exhausted_r, out_element_r != '0)
  `KPE_ASSERT_NOW(a_take_free, cmd.take_pos || cmd.fill_take, !sts.scan_over && sts.scan_free)
  `KPE_ASSERT_NOW(a_used_count, cmd.emit_elem, $countones(used_r) == 32'(k_cnt))
  `KPE_ASSERT_NEXT(a_emit_shows, cmd.emit_elem || cmd.emit_exh, out_valid_r)

endmodule

>>> rtl/core/k_permutation_enumerator.sv
// channel   | direction | handshake          | payload
// in_       | input     | in_valid/in_ready  | in_restart
// out_      | output    | out_valid/out_ready| element, position, ordinal, last, exhausted
// cfg_      | input     | cfg_we             | cfg_index, cfg_wdata
// one transaction at a time; in_ready is high only while the controller is idle
// a start loads 1..k into the tuple ram, then emits each element read back from the tuple ram
// an advance backtracks from the right, releasing each value and scanning up for a free one,
// then refills later positions with the smallest free values and emits each element likewise
// out_ready low holds the result register and stalls the controller; sync reset, no clear pass
module k_permutation_enumerator
  import kpe_pkg::*;
  #(
    parameter int MAX_SET   = KPE_MAX_SET_DEF,
    parameter int MAX_TUPLE = KPE_MAX_TUPLE_DEF
  )
  (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 in_restart,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [ELEM_W-1:0]    out_element,
    output logic [POS_W-1:0]     out_position,
    output logic [ORD_W-1:0]     out_ordinal,
    output logic                 out_last,
    output logic                 out_exhausted
  );

  cmd_t cmd;
  sts_t sts;

  kpe_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_restart (in_restart),
    .sts        (sts),
    .cmd        (cmd)
  );

  kpe_dp #(
    .MAX_SET   (MAX_SET),
    .MAX_TUPLE (MAX_TUPLE)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_element   (out_element),
    .out_position  (out_position),
    .out_ordinal   (out_ordinal),
    .out_last      (out_last),
    .out_exhausted (out_exhausted)
  );

endmodule

>>> test/tb.sv
module tb;
  import kpe_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int TAIL_CYCLES = 20;
  localparam int MAX_PRINTS  = 50;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    logic [ELEM_W-1:0] element;
    logic [POS_W-1:0]  position;
    logic [ORD_W-1:0]  ordinal;
    logic              last;
    logic              exhausted;
  } tuple_elem_t;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = REG_SET_SIZE;
  logic [CFG_W-1:0]     cfg_wdata  = '0;
  logic                 in_valid   = 1'b0;
  logic                 in_restart = 1'b0;
  logic                 out_ready  = 1'b0;
  logic                 in_ready;
  logic                 out_valid;
  logic [ELEM_W-1:0]    out_element;
  logic [POS_W-1:0]     out_position;
  logic [ORD_W-1:0]     out_ordinal;
  logic                 out_last;
  logic                 out_exhausted;

  // shadow of the enumerator state
  logic [CFG_W-1:0]            mdl_n = SET_SIZE_RST;
  logic [CFG_W-1:0]            mdl_k = TUPLE_LEN_RST;
  logic [ELEM_W-1:0]           perm_vals [KPE_MAX_TUPLE_DEF];
  logic [KPE_MAX_SET_DEF-1:0]  perm_used = '0;
  bit                          perm_started = 1'b0;
  bit                          perm_done = 1'b0;
  logic [ORD_W-1:0]            perm_count = '0;

  tuple_elem_t expected_elems [$];

  int mismatch_cnt   = 0;
  int cycle_cnt      = 0;
  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int hold_left      = 0;

  k_permutation_enumerator dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_restart    (in_restart),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_element   (out_element),
    .out_position  (out_position),
    .out_ordinal   (out_ordinal),
    .out_last      (out_last),
    .out_exhausted (out_exhausted)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               expected_elems.size());
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [ORD_W-1:0] want,
                                 input logic [ORD_W-1:0] got);
    if (mismatch_cnt < MAX_PRINTS)
      $display("cycle %0d: %s mismatch, expected %0d got %0d", cycle_cnt, what, want, got);
    mismatch_cnt++;
  endtask

  function automatic int smallest_free(input int floor_val);
    int v;
    for (v = floor_val + 1; v <= int'(mdl_n); v++)
      if (!perm_used[v-1])
        return v;
    return 0;
  endfunction

  function automatic void push_exhausted();
    tuple_elem_t e;
    e.element   = '0;
    e.position  = '0;
    e.ordinal   = perm_count;
    e.last      = 1'b1;
    e.exhausted = 1'b1;
    expected_elems.push_back(e);
  endfunction

  function automatic void push_tuple();
    tuple_elem_t e;
    int i;
    for (i = 0; i < int'(mdl_k); i++) begin
      e.element   = perm_vals[i];
      e.position  = POS_W'(i);
      e.ordinal   = perm_count;
      e.last      = (i == int'(mdl_k) - 1);
      e.exhausted = 1'b0;
      expected_elems.push_back(e);
    end
  endfunction

  // works out the results of one transaction and updates the shadow state
  task automatic predict_next_tuple(input logic restart);
    int i, pos, q, v;
    bit found;
    if (restart || !perm_started) begin
      perm_started = 1'b1;
      perm_done    = 1'b0;
      perm_count   = '0;
      perm_used    = '0;
      if (mdl_n < 1 || mdl_k < 1 || mdl_k > mdl_n || mdl_n > KPE_MAX_SET_DEF ||
          mdl_k > KPE_MAX_TUPLE_DEF) begin
        perm_done = 1'b1;
        push_exhausted();
        return;
      end
      for (i = 0; i < int'(mdl_k); i++) begin
        perm_vals[i] = ELEM_W'(i + 1);
        perm_used[i] = 1'b1;
      end
      perm_count = 1;
      push_tuple();
      return;
    end
    if (perm_done) begin
      push_exhausted();
      return;
    end
    // backtrack from the right until some position can be raised
    found = 1'b0;
    for (pos = int'(mdl_k) - 1; pos >= 0 && !found; pos--) begin
      perm_used[int'(perm_vals[pos]) - 1] = 1'b0;
      v = smallest_free(int'(perm_vals[pos]));
      if (v != 0) begin
        found = 1'b1;
        perm_vals[pos] = ELEM_W'(v);
        perm_used[v-1] = 1'b1;
        for (q = pos + 1; q < int'(mdl_k); q++) begin
          v = smallest_free(0);
          perm_vals[q] = ELEM_W'(v);
          perm_used[v-1] = 1'b1;
        end
      end
    end
    if (!found) begin
      perm_done = 1'b1;
      push_exhausted();
      return;
    end
    if (perm_count != '1)
      perm_count++;
    push_tuple();
  endtask

  always @(posedge clk) begin
    tuple_elem_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_elems.size() == 0) begin
        report_mismatch("unexpected result, element", '0, ORD_W'(out_element));
      end else begin
        want = expected_elems.pop_front();
        if (out_element !== want.element)
          report_mismatch("element", ORD_W'(want.element), ORD_W'(out_element));
        if (out_position !== want.position)
          report_mismatch("position", ORD_W'(want.position), ORD_W'(out_position));
        if (out_ordinal !== want.ordinal)
          report_mismatch("ordinal", want.ordinal, out_ordinal);
        if (out_last !== want.last)
          report_mismatch("last", ORD_W'(want.last), ORD_W'(out_last));
        if (out_exhausted !== want.exhausted)
          report_mismatch("exhausted", ORD_W'(want.exhausted), ORD_W'(out_exhausted));
      end
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // offers one transaction; valid stays high on return unless a gap was taken
  task automatic send_item(input logic restart);
    in_valid   <= 1'b1;
    in_restart <= restart;
    do @(posedge clk); while (!in_ready);
    predict_next_tuple(restart);
    if ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
  endtask

  // stop offering, wait for every result and for the controller to go idle
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_elems.size() != 0)
      @(posedge clk);
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_sizes(input bit wr_n, input logic [CFG_W-1:0] n,
                             input bit wr_k, input logic [CFG_W-1:0] k);
    drain();
    if (wr_n) begin
      cfg_we    <= 1'b1;
      cfg_index <= REG_SET_SIZE;
      cfg_wdata <= n;
      @(posedge clk);
      mdl_n = n;
      perm_started = 1'b0;
    end
    if (wr_k) begin
      cfg_we    <= 1'b1;
      cfg_index <= REG_TUPLE_LEN;
      cfg_wdata <= k;
      @(posedge clk);
      mdl_k = k;
      perm_started = 1'b0;
    end
    cfg_we <= 1'b0;
  endtask

  task automatic test_directed();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    // reset sizes, first advance starts the enumeration
    repeat (3) send_item(1'b0);
    send_item(1'b1);
    send_item(1'b0);
    // run 3 of 3 to the end, two calls past the end, then restart
    write_sizes(1'b1, 5'd3, 1'b1, 5'd3);
    repeat (8) send_item(1'b0);
    send_item(1'b1);
    write_sizes(1'b1, 5'd1, 1'b1, 5'd1);
    repeat (2) send_item(1'b0);
    // empty and impossible sizes
    write_sizes(1'b1, 5'd0, 1'b0, 5'd0);
    send_item(1'b0);
    write_sizes(1'b1, 5'd5, 1'b1, 5'd0);
    send_item(1'b0);
    write_sizes(1'b1, 5'd3, 1'b1, 5'd5);
    send_item(1'b0);
    write_sizes(1'b1, 5'd31, 1'b1, 5'd31);
    send_item(1'b0);
    send_item(1'b1);
    // widest tuple
    write_sizes(1'b1, 5'd16, 1'b1, 5'd16);
    repeat (2) send_item(1'b0);
    send_item(1'b1);
    write_sizes(1'b1, 5'd16, 1'b1, 5'd1);
    send_item(1'b0);
  endtask

  task automatic test_random_phase(input int src_pct, input int sink_pct, input int n_items);
    int sent, burst, r;
    logic [CFG_W-1:0] n, k;
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(99);
      if (r < 60) begin
        n = CFG_W'($urandom_range(1, 5));
        k = CFG_W'($urandom_range(1, int'(n)));
        write_sizes(1'b1, n, 1'b1, k);
      end else if (r < 75) begin
        n = CFG_W'($urandom_range(6, 16));
        k = CFG_W'($urandom_range(1, 3));
        write_sizes(1'b1, n, 1'b1, k);
      end else if (r < 82) begin
        write_sizes(1'b1, 5'd16, 1'b1, 5'($urandom_range(12, 16)));
      end else if (r < 92) begin
        write_sizes(1'b1, 5'($urandom_range(0, 31)), 1'b1, 5'($urandom_range(0, 31)));
      end else begin
        // one register only, the other keeps its value
        n = CFG_W'($urandom_range(0, 31));
        if ($urandom_range(1))
          write_sizes(1'b1, n, 1'b0, n);
        else
          write_sizes(1'b0, n, 1'b1, n);
      end
      burst = (mdl_k >= 12) ? $urandom_range(1, 4) : $urandom_range(3, 24);
      repeat (burst) begin
        send_item($urandom_range(99) < 8);
        sent++;
      end
    end
  endtask

  task automatic test_random();
    test_random_phase(0, 0, 80);
    test_random_phase(75, 0, 80);
    test_random_phase(0, 75, 80);
    test_random_phase(23, 23, 80);
  endtask

  task automatic test_backpressure();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    write_sizes(1'b1, 5'd4, 1'b1, 5'd3);
    // receiver holds off while the sender keeps offering
    hold_left = HOLD_CYCLES;
    repeat (8) send_item(1'b0);
    // sender pauses until every result is back
    drain();
    repeat (6) send_item(1'($urandom_range(1)));
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random();
    test_backpressure();
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
